// ----- design/svd_pkg.sv -----
// Shared constants and helpers for the stereo vibrato delay.
// Holds sample widths, register offsets, sine polynomial coefficients and
// the 24-bit saturation helper. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svd_pkg;

  // Sample and frame widths
  localparam int SAMPLE_W = 24;
  localparam int FRAME_W  = 2 * SAMPLE_W;

  // Quarter-wave sine table size; a power of two so the table index is a bit slice
  localparam int SINE_TABLE_SIZE = 256;

  // Register indexes (byte address divided by four)
  localparam logic [2:0] REG_ENABLE        = 3'd0;
  localparam logic [2:0] REG_LFO_STEP      = 3'd1;
  localparam logic [2:0] REG_SWEEP_DEPTH   = 3'd2;
  localparam logic [2:0] REG_WET_MIX       = 3'd3;
  localparam logic [2:0] REG_BUFFER_LENGTH = 3'd4;

  // Register reset values
  localparam logic [23:0] LFO_STEP_RESET    = 24'd447392;
  localparam logic [24:0] SWEEP_DEPTH_RESET = 25'd4718592;
  localparam logic [15:0] WET_MIX_UNITY     = 16'h8000;
  localparam int          LEN_DEFAULT       = 2400;
  localparam int          LEN_MIN           = 16;

  // Odd sine polynomial coefficients in Q30
  localparam logic [30:0] SINE_C1 = 31'd1686629713;
  localparam logic [30:0] SINE_C3 = 31'd693598668;
  localparam logic [30:0] SINE_C5 = 31'd85569306;
  localparam logic [30:0] SINE_C7 = 31'd5026995;
  localparam logic [30:0] SINE_C9 = 31'd172271;

  // Clip a widened sum back into the 24-bit sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_sample(
    input logic signed [SAMPLE_W+2:0] v
  );
    logic signed [SAMPLE_W-1:0] r;
    if ((v[SAMPLE_W+2:SAMPLE_W-1] == 4'b0000) || (v[SAMPLE_W+2:SAMPLE_W-1] == 4'b1111)) begin
      r = v[SAMPLE_W-1:0];
    end else if (v[SAMPLE_W+2]) begin
      r = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/stereo_vibrato_delay.sv -----
// Stereo vibrato: sine LFO sweeps a fractional delay read from one stereo store.
// One frame at a time: a new frame is taken only once the last result is
// registered, as the single shared 32x32 multiplier steps the sine
// polynomial, delay, interpolation and mix in turn. Bypassed frames skip it.
// Synchronous reset: registers to defaults, LFO phase and write index to 0,
// delay store reads as zero until written (fill count, no clearing pass).
`timescale 1ns / 1ps
`default_nettype none

module stereo_vibrato_delay
  import svd_pkg::*;
#(
  parameter int STORE_DEPTH = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [4:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // input frames
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] left_sample,
  input  logic signed [SAMPLE_W-1:0] right_sample,
  // output frames
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] left_result,
  output logic signed [SAMPLE_W-1:0] right_result
);

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int LW  = AW + 1;
  localparam int TW  = $clog2(SINE_TABLE_SIZE);   // table size is a power of two
  localparam int TSH = 30 - TW;
  localparam int PW  = ((AW + 16) > 27 ? (AW + 16) : 27) + 2;
  localparam logic [LW-1:0] LEN_RESET =
    (LEN_DEFAULT > STORE_DEPTH) ? LW'(STORE_DEPTH) : LW'(LEN_DEFAULT);
  localparam logic [TW:0]          TBL_FULL = (TW+1)'(SINE_TABLE_SIZE);
  localparam logic signed [PW-1:0] Q16_ONE  = PW'(65536);

  typedef enum logic [4:0] {
    S_IDLE, S_SQ, S_X2, S_P7, S_M7, S_P5, S_M5, S_P3, S_M3, S_P1, S_MS,
    S_LFO, S_MD, S_POS, S_WRAP, S_RD0, S_RD1, S_D1, S_IL, S_IR, S_WR,
    S_BL, S_BR, S_RES, S_DONE
  } state_t;

  state_t state;

  // configuration registers
  logic          enable;
  logic [23:0]   lfo_step;
  logic [24:0]   sweep_depth;
  logic [15:0]   wet_mix;
  logic [LW-1:0] buffer_length;

  // running state
  logic [AW-1:0] write_position;
  logic [31:0]   lfo_phase;

  // datapath registers
  logic [AW-1:0]              wp_cur;
  logic [30:0]                t_val;
  logic                       quad_neg;
  logic [30:0]                x2;
  logic [30:0]                p_val;
  logic [15:0]                lfo_ofs;
  logic signed [PW-1:0]       pos;
  logic [AW-1:0]              i0;
  logic [AW-1:0]              i1;
  logic [15:0]                frac;
  logic signed [SAMPLE_W-1:0] dry_l, dry_r;
  logic signed [SAMPLE_W-1:0] s0_l, s0_r;
  logic signed [SAMPLE_W:0]   dif_l, dif_r;
  logic signed [SAMPLE_W-1:0] wet_l, wet_r;
  logic signed [SAMPLE_W:0]   bd_l, bd_r;
  logic signed [SAMPLE_W-1:0] res_l, res_r;
  logic signed [63:0]         prod;

  // shared multiplier operands
  logic signed [31:0] mul_a, mul_b;

  // combinational helpers
  logic                       cfg_wr, cfg_len_wr, accept;
  logic [13:0]                len_raw;
  logic [LW-1:0]              len_clamped;
  logic [15:0]                mix_clamped;
  logic [AW-1:0]              wp_eff, wp_nxt;
  logic [LW-1:0]              wp_inc;
  logic [TW-1:0]              idx;
  logic [TW:0]                k_sel;
  logic [30:0]                t_calc;
  logic [30:0]                c_sel;
  logic [31:0]                p_next;
  logic [32:0]                s_round;
  logic [17:0]                q_raw;
  logic [14:0]                q_cap;
  logic [15:0]                lfo_ofs_calc;
  logic signed [PW-1:0]       pos_base, dly, pos_calc, len_q16, pos_add, pos_w, pos_c;
  logic [LW-1:0]              i0_inc;
  logic [FRAME_W-1:0]         rd_data;
  logic [AW-1:0]              rd_addr;
  logic signed [SAMPLE_W-1:0] rd_l, rd_r;
  logic signed [SAMPLE_W-1:0] s0_sel, dry_sel;
  logic signed [SAMPLE_W:0]   wet_sum;
  logic signed [SAMPLE_W+2:0] mix_sum;

  // ---------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign cfg_len_wr = cfg_wr && (paddr[4:2] == REG_BUFFER_LENGTH);

  // Clamp length into the store and mix to unity
  assign len_raw     = {1'b0, pwdata[12:0]};
  assign len_clamped = (len_raw < 14'(LEN_MIN))     ? LW'(LEN_MIN) :
                       (len_raw > 14'(STORE_DEPTH)) ? LW'(STORE_DEPTH) :
                                                      LW'(len_raw);
  assign mix_clamped = (pwdata[15:0] > WET_MIX_UNITY) ? WET_MIX_UNITY : pwdata[15:0];

  // Hold register values, update on a write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      enable        <= 1'b1;
      lfo_step      <= LFO_STEP_RESET;
      sweep_depth   <= SWEEP_DEPTH_RESET;
      wet_mix       <= WET_MIX_UNITY;
      buffer_length <= LEN_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_ENABLE:        enable        <= pwdata[0];
        REG_LFO_STEP:      lfo_step      <= pwdata[23:0];
        REG_SWEEP_DEPTH:   sweep_depth   <= pwdata[24:0];
        REG_WET_MIX:       wet_mix       <= mix_clamped;
        REG_BUFFER_LENGTH: buffer_length <= len_clamped;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (paddr[4:2])
      REG_ENABLE:        prdata = {31'd0, enable};
      REG_LFO_STEP:      prdata = {8'd0, lfo_step};
      REG_SWEEP_DEPTH:   prdata = {7'd0, sweep_depth};
      REG_WET_MIX:       prdata = {16'd0, wet_mix};
      REG_BUFFER_LENGTH: prdata = 32'(buffer_length);
      default:           prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Frame entry: write index, LFO table position
  // ---------------------------------------------------------------------
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  assign wp_eff = ({1'b0, write_position} >= buffer_length) ? '0 : write_position;
  assign wp_inc = {1'b0, wp_eff} + LW'(1);
  assign wp_nxt = (wp_inc == buffer_length) ? '0 : wp_inc[AW-1:0];

  // Mirror the table index in odd quadrants, scale it back up to Q30
  assign idx    = lfo_phase[29:TSH];
  assign k_sel  = lfo_phase[30] ? (TBL_FULL - {1'b0, idx}) : {1'b0, idx};
  assign t_calc = {k_sel, {TSH{1'b0}}};

  // ---------------------------------------------------------------------
  // Product post-processing
  // ---------------------------------------------------------------------
  always_comb begin
    case (state)
      S_P7:    c_sel = SINE_C7;
      S_P5:    c_sel = SINE_C5;
      S_P3:    c_sel = SINE_C3;
      default: c_sel = SINE_C1;
    endcase
  end

  assign p_next = {1'b0, c_sel} - prod[61:30];

  // Round sine to Q1.15, cap, then offset by one so the swing is unsigned
  assign s_round      = {1'b0, prod[61:30]} + 33'd16384;
  assign q_raw        = s_round[32:15];
  assign q_cap        = (q_raw > 18'd32767) ? 15'h7FFF : q_raw[14:0];
  assign lfo_ofs_calc = quad_neg ? (16'h8000 - {1'b0, q_cap}) : (16'h8000 + {1'b0, q_cap});

  // Read position: write index less delay (delay = swing + one sample)
  assign pos_base = signed'({{(PW-AW-16){1'b0}}, wp_cur, 16'h0000});
  assign dly      = signed'({{(PW-27){1'b0}}, prod[41:15]});
  assign pos_calc = pos_base - dly - Q16_ONE;

  // Wrap once by the active length, clip anything still negative
  assign len_q16 = signed'({{(PW-LW-16){1'b0}}, buffer_length, 16'h0000});
  assign pos_add = pos + len_q16;
  assign pos_w   = pos[PW-1] ? pos_add : pos;
  assign pos_c   = pos_w[PW-1] ? '0 : pos_w;

  assign i0_inc = {1'b0, i0} + LW'(1);

  // Interpolation and mix sums
  assign rd_l    = rd_data[FRAME_W-1:SAMPLE_W];
  assign rd_r    = rd_data[SAMPLE_W-1:0];
  assign s0_sel  = (state == S_IR) ? s0_l : s0_r;
  assign dry_sel = (state == S_BR) ? dry_l : dry_r;
  assign wet_sum = $signed({s0_sel[SAMPLE_W-1], s0_sel}) + $signed(prod[40:16]);
  assign mix_sum = $signed({{3{dry_sel[SAMPLE_W-1]}}, dry_sel})
                 + $signed({prod[40], prod[40:15]});

  // ---------------------------------------------------------------------
  // Shared multiplier operand select
  // ---------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state) inside
      S_SQ: begin
        mul_a = {1'b0, t_val};
        mul_b = {1'b0, t_val};
      end
      S_X2: begin
        mul_a = {1'b0, prod[60:30]};
        mul_b = {1'b0, SINE_C9};
      end
      S_M7, S_M5, S_M3: begin
        mul_a = {1'b0, x2};
        mul_b = {1'b0, p_val};
      end
      S_MS: begin
        mul_a = {1'b0, t_val};
        mul_b = {1'b0, p_val};
      end
      S_MD: begin
        mul_a = {7'd0, sweep_depth};
        mul_b = {16'd0, lfo_ofs};
      end
      S_IL: begin
        mul_a = {{7{dif_l[SAMPLE_W]}}, dif_l};
        mul_b = {16'd0, frac};
      end
      S_IR: begin
        mul_a = {{7{dif_r[SAMPLE_W]}}, dif_r};
        mul_b = {16'd0, frac};
      end
      S_BL: begin
        mul_a = {{7{bd_l[SAMPLE_W]}}, bd_l};
        mul_b = {16'd0, wet_mix};
      end
      S_BR: begin
        mul_a = {{7{bd_r[SAMPLE_W]}}, bd_r};
        mul_b = {16'd0, wet_mix};
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Delay store
  // ---------------------------------------------------------------------
  assign rd_addr = (state == S_RD1) ? i1 : i0;

  svd_store #(
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (accept && enable),
    .wr_addr (wp_eff),
    .wr_data ({left_sample, right_sample}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------------
  // Sequencer, running state and output register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      left_result    <= '0;
      right_result   <= '0;
      write_position <= '0;
      lfo_phase      <= '0;
    end else begin
      // drop the result once it has been taken
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_len_wr) begin
        write_position <= '0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (enable) begin
              write_position <= wp_nxt;
              lfo_phase      <= lfo_phase + {8'h00, lfo_step};
              state          <= S_SQ;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_SQ:   state <= S_X2;
        S_X2:   state <= S_P7;
        S_P7:   state <= S_M7;
        S_M7:   state <= S_P5;
        S_P5:   state <= S_M5;
        S_M5:   state <= S_P3;
        S_P3:   state <= S_M3;
        S_M3:   state <= S_P1;
        S_P1:   state <= S_MS;
        S_MS:   state <= S_LFO;
        S_LFO:  state <= S_MD;
        S_MD:   state <= S_POS;
        S_POS:  state <= S_WRAP;
        S_WRAP: state <= S_RD0;
        S_RD0:  state <= S_RD1;
        S_RD1:  state <= S_D1;
        S_D1:   state <= S_IL;
        S_IL:   state <= S_IR;
        S_IR:   state <= S_WR;
        S_WR:   state <= S_BL;
        S_BL:   state <= S_BR;
        S_BR:   state <= S_RES;
        S_RES:  state <= S_DONE;
        S_DONE: begin
          // hold until the output register is free
          if (!out_valid || out_ready) begin
            left_result  <= res_l;
            right_result <= res_r;
            out_valid    <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (state)
      S_IDLE: begin
        // capture the frame; the dry copy doubles as the bypass result
        dry_l    <= left_sample;
        dry_r    <= right_sample;
        res_l    <= left_sample;
        res_r    <= right_sample;
        wp_cur   <= wp_eff;
        t_val    <= t_calc;
        quad_neg <= lfo_phase[31];
      end
      S_X2:  x2 <= prod[60:30];
      S_P7:  p_val <= p_next[30:0];
      S_P5:  p_val <= p_next[30:0];
      S_P3:  p_val <= p_next[30:0];
      S_P1:  p_val <= p_next[30:0];
      S_LFO: lfo_ofs <= lfo_ofs_calc;
      S_POS: pos <= pos_calc;
      S_WRAP: begin
        i0   <= pos_c[AW+15:16];
        frac <= pos_c[15:0];
      end
      S_RD0: i1 <= (i0_inc == buffer_length) ? '0 : i0_inc[AW-1:0];
      S_RD1: begin
        s0_l <= rd_l;
        s0_r <= rd_r;
      end
      S_D1: begin
        dif_l <= $signed({rd_l[SAMPLE_W-1], rd_l}) - $signed({s0_l[SAMPLE_W-1], s0_l});
        dif_r <= $signed({rd_r[SAMPLE_W-1], rd_r}) - $signed({s0_r[SAMPLE_W-1], s0_r});
      end
      S_IR: wet_l <= wet_sum[SAMPLE_W-1:0];
      S_WR: begin
        wet_r <= wet_sum[SAMPLE_W-1:0];
        bd_l  <= $signed({wet_l[SAMPLE_W-1], wet_l}) - $signed({dry_l[SAMPLE_W-1], dry_l});
      end
      S_BL: bd_r <= $signed({wet_r[SAMPLE_W-1], wet_r}) - $signed({dry_r[SAMPLE_W-1], dry_r});
      S_BR: res_l <= sat_sample(mix_sum);
      S_RES: res_r <= sat_sample(mix_sum);
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/svd_store.sv -----
// Stereo delay memory: one frame word per entry, one write and one read port.
// Tracks how far the store has been filled so unwritten entries read as zero.
// Depends on svd_pkg for the frame width.
`timescale 1ns / 1ps
`default_nettype none

module svd_store
  import svd_pkg::*;
#(
  parameter int DEPTH = 4096,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [AW-1:0]      wr_addr,
  input  logic [FRAME_W-1:0] wr_data,
  input  logic [AW-1:0]      rd_addr,
  output logic [FRAME_W-1:0] rd_data
);

  logic [FRAME_W-1:0] mem [DEPTH];
  logic [FRAME_W-1:0] rd_raw;
  logic               rd_hit;
  logic [AW:0]        fill;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_raw <= mem[rd_addr];
  end

  // Writes always land at or just past the filled prefix; extend it
  always_ff @(posedge clk) begin
    if (rst) begin
      fill   <= '0;
      rd_hit <= 1'b0;
    end else begin
      rd_hit <= ({1'b0, rd_addr} < fill);
      if (wr_en && ({1'b0, wr_addr} >= fill)) begin
        fill <= {1'b0, wr_addr} + (AW+1)'(1);
      end
    end
  end

  // Entries beyond the filled prefix read as zero; the memory itself is not cleared
  assign rd_data = rd_hit ? rd_raw : '0;

endmodule

`default_nettype wire
